// ===== rtl/core/vcef_pkg.sv =====
`default_nettype none

package vcef_pkg;

  // print line geometry
  localparam int LINE_WIDTH = 72;
  localparam int COL_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int RUN_W      = 7;
  localparam logic [COL_W-1:0] LINE_END = COL_W'(LINE_WIDTH);

  // signed width for column targets: column +/- a 255 argument
  localparam int TGT_W = 10;
  localparam logic signed [TGT_W-1:0] TGT_MAX = TGT_W'(LINE_WIDTH);

  // control bytes
  localparam logic [BYTE_W-1:0] B_ESC = 8'h1B;
  localparam logic [BYTE_W-1:0] B_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] B_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] B_SP  = 8'h20;
  localparam logic [BYTE_W-1:0] B_DEL = 8'h7F;

  // sequence bytes
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_QUESTION = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_PLUS     = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SAVE     = 8'h37;
  localparam logic [BYTE_W-1:0] CH_RESTORE  = 8'h38;
  localparam logic [BYTE_W-1:0] CH_UP_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_Z     = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LO_A     = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LO_Z     = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_DOWN     = 8'h42;
  localparam logic [BYTE_W-1:0] CH_RIGHT    = 8'h43;
  localparam logic [BYTE_W-1:0] CH_LEFT     = 8'h44;
  localparam logic [BYTE_W-1:0] CH_COLUMN   = 8'h47;
  localparam logic [BYTE_W-1:0] CH_SET      = 8'h68;
  localparam logic [BYTE_W-1:0] CH_CLEAR    = 8'h6C;
  localparam logic [BYTE_W-1:0] CH_SOFT_RST = 8'h70;

  localparam logic [TGT_W-1:0] WRAP_MODE = 10'd7;

  // argument parser status
  localparam logic [1:0] ARG_IDLE   = 2'd0;
  localparam logic [1:0] ARG_SIGN   = 2'd1;
  localparam logic [1:0] ARG_DIGITS = 2'd2;
  localparam logic [1:0] ARG_CLOSED = 2'd3;

  localparam logic [7:0] ARG_SAT = 8'd255;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic [RUN_W-1:0]  count;
    logic [COL_W-1:0]  col;
  } run_t;

  // one input byte's worth of runs, n_runs from 1 to 3
  typedef struct packed {
    logic [1:0]      n_runs;
    run_t [2:0]      runs;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/vcef_in_if.sv =====
`default_nettype none

interface vcef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vcef_out_if.sv =====
`default_nettype none

interface vcef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [6:0] run_count;
  logic [6:0] column_after;
  logic       last_run;

  modport source (output valid, output out_byte, output run_count, output column_after,
                  output last_run, input ready);
  modport sink (input valid, input out_byte, input run_count, input column_after,
                input last_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vt100_column_escape_filter_core.sv =====
`default_nettype none

// channel   dir  payload                                        handshake
// in_ch     in   in_byte[7:0]                                   valid/ready
// out_ch    out  out_byte[7:0] run_count[6:0] column_after[6:0]  valid/ready
//                last_run
//
// one byte accepted per cycle while the run queue is not full, one run
// item delivered per cycle while out_ch is ready; a byte causing n runs
// yields n run items in turn, the last marked by last_run; the first run
// passes the run queue and then the output register before it is valid
// rst (synchronous) clears the parser, column, wrap mode and the queue
// in_ch.ready drops only while the four-entry run queue is full; a stalled
// out_ch keeps its item in the output register while the front goes on

module vt100_column_escape_filter_core (
  input  wire logic  clk,
  input  wire logic  rst,
  vcef_in_if.sink    in_ch,
  vcef_out_if.source out_ch
);

  // front to queue
  vcef_pkg::cmd_t cmd;
  logic           cmd_push;

  // queue to back
  vcef_pkg::cmd_t head;
  logic           q_empty;
  logic           q_full;
  logic           q_pop;

  // parser, column tracking and run generation, one byte per cycle while the queue is not full
  vcef_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cmd      (cmd),
    .cmd_push (cmd_push),
    .cmd_full (q_full)
  );

  // short queue of per-byte run groups so each side stalls on its own
  vcef_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // serializes each group into run items behind an output register
  vcef_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/vcef_front.sv =====
`default_nettype none

module vcef_front (
  input  wire logic         clk,
  input  wire logic         rst,
  vcef_in_if.sink           in_ch,
  output vcef_pkg::cmd_t    cmd,
  output logic              cmd_push,
  input  wire logic         cmd_full
);

  logic       accept;
  logic [7:0] b;

  // parser and column state
  logic       in_esc, in_esc_next;
  logic [1:0] seq_count, seq_count_next;
  logic       csi_flag, csi_flag_next;
  logic       question_flag, question_flag_next;
  logic [7:0] arg_value, arg_value_next;
  logic       arg_negative, arg_negative_next;
  logic [1:0] arg_status, arg_status_next;
  logic [vcef_pkg::COL_W-1:0] print_column, print_column_next;
  logic [vcef_pkg::COL_W-1:0] saved_column, saved_column_next;
  logic       wrap_enable, wrap_enable_next;

  logic [1:0] cnt;
  logic [1:0] k;
  logic       is_letter, is_digit, is_print, simple;
  logic [3:0] digit_val;
  logic [11:0] arg_wide;
  logic       arg_found;
  logic signed [vcef_pkg::TGT_W-1:0] arg_signed, arg_one, arg_zero, col_s, tgt;
  logic [vcef_pkg::COL_W-1:0] tc, col_w;
  logic       move_en;

  assign in_ch.ready = !cmd_full;
  assign accept      = in_ch.valid && !cmd_full;
  assign b           = in_ch.in_byte;

  assign is_letter = (b >= vcef_pkg::CH_UP_A && b <= vcef_pkg::CH_UP_Z) ||
                     (b >= vcef_pkg::CH_LO_A && b <= vcef_pkg::CH_LO_Z);
  assign is_digit  = (b >= vcef_pkg::CH_ZERO && b <= vcef_pkg::CH_NINE);
  assign is_print  = (b >= vcef_pkg::B_SP && b < vcef_pkg::B_DEL);
  assign digit_val = b[3:0];
  assign cnt       = (seq_count == 2'd3) ? 2'd3 : seq_count + 2'd1;
  assign simple    = (cnt == 2'd1);
  assign arg_wide  = {1'b0, arg_value, 3'b000} + {3'b000, arg_value, 1'b0} +
                     {8'd0, digit_val};

  // argument as seen by the final byte, with the command defaults
  assign arg_found  = (arg_status == vcef_pkg::ARG_DIGITS) ||
                      (arg_status == vcef_pkg::ARG_CLOSED &&
                       !(arg_negative && arg_value == 8'd0));
  assign arg_signed = arg_negative ? -$signed({2'b00, arg_value})
                                   : $signed({2'b00, arg_value});
  assign arg_one    = arg_found ? arg_signed : 10'sd1;
  assign arg_zero   = arg_found ? arg_signed : 10'sd0;
  assign col_s      = $signed({3'b000, print_column});

  always_comb begin
    in_esc_next        = in_esc;
    seq_count_next     = seq_count;
    csi_flag_next      = csi_flag;
    question_flag_next = question_flag;
    arg_value_next     = arg_value;
    arg_negative_next  = arg_negative;
    arg_status_next    = arg_status;
    print_column_next  = print_column;
    saved_column_next  = saved_column;
    wrap_enable_next   = wrap_enable;
    cmd      = '0;
    k        = 2'd0;
    move_en  = 1'b0;
    tgt      = col_s;
    tc       = '0;
    col_w    = print_column;

    if (!in_esc) begin
      if (b == vcef_pkg::B_ESC) begin
        in_esc_next        = 1'b1;
        seq_count_next     = 2'd0;
        csi_flag_next      = 1'b0;
        question_flag_next = 1'b0;
        arg_value_next     = 8'd0;
        arg_negative_next  = 1'b0;
        arg_status_next    = vcef_pkg::ARG_IDLE;
      end else begin
        // wrap only for passed-through bytes at full width
        if (wrap_enable && print_column == vcef_pkg::LINE_END) begin
          col_w = '0;
          cmd.runs[0] = {vcef_pkg::B_CR, 7'd1, 7'd0};
          cmd.runs[1] = {vcef_pkg::B_LF, 7'd1, 7'd0};
          k = 2'd2;
        end
        if (b == vcef_pkg::B_CR) begin
          col_w = '0;
        end else if (is_print && col_w < vcef_pkg::LINE_END) begin
          col_w = col_w + 7'd1;
        end
        cmd.runs[k] = {b, 7'd1, col_w};
        k = k + 2'd1;
        print_column_next = col_w;
      end
    end else begin
      seq_count_next = cnt;
      if (is_letter || (simple && is_digit)) begin
        in_esc_next = 1'b0;
        if (simple) begin
          unique case (b)
            vcef_pkg::CH_DOWN: begin
              cmd.runs[0] = {vcef_pkg::B_LF, 7'd1, print_column};
              k = 2'd1;
            end
            vcef_pkg::CH_RIGHT: begin
              move_en = 1'b1;
              tgt = col_s + 10'sd1;
            end
            vcef_pkg::CH_LEFT: begin
              move_en = 1'b1;
              tgt = col_s - 10'sd1;
            end
            vcef_pkg::CH_SAVE: saved_column_next = print_column;
            vcef_pkg::CH_RESTORE: begin
              move_en = 1'b1;
              tgt = $signed({3'b000, saved_column});
            end
            default: ;
          endcase
        end else if (csi_flag && !question_flag) begin
          unique case (b)
            vcef_pkg::CH_RIGHT: begin
              move_en = 1'b1;
              tgt = col_s + arg_one;
            end
            vcef_pkg::CH_LEFT: begin
              move_en = 1'b1;
              tgt = col_s - arg_one;
            end
            vcef_pkg::CH_COLUMN: begin
              move_en = 1'b1;
              tgt = arg_zero;
            end
            default: ;
          endcase
        end else if (csi_flag) begin
          unique case (b)
            vcef_pkg::CH_SET: begin
              if (arg_zero == $signed(vcef_pkg::WRAP_MODE)) wrap_enable_next = 1'b1;
            end
            vcef_pkg::CH_CLEAR: begin
              if (arg_zero == $signed(vcef_pkg::WRAP_MODE)) wrap_enable_next = 1'b0;
            end
            vcef_pkg::CH_SOFT_RST: begin
              wrap_enable_next  = 1'b0;
              print_column_next = '0;
              cmd.runs[0] = {vcef_pkg::B_CR, 7'd1, 7'd0};
              cmd.runs[1] = {vcef_pkg::B_LF, 7'd1, 7'd0};
              k = 2'd2;
            end
            default: ;
          endcase
        end
      end else if (simple && b == vcef_pkg::CH_LBRACKET) begin
        csi_flag_next = 1'b1;
      end else if (csi_flag && cnt == 2'd2 && b == vcef_pkg::CH_QUESTION) begin
        question_flag_next = 1'b1;
      end else if (csi_flag && cnt != 2'd1) begin
        // decimal argument with optional sign
        unique case (arg_status)
          vcef_pkg::ARG_IDLE: begin
            if (b == vcef_pkg::CH_PLUS) begin
              arg_status_next   = vcef_pkg::ARG_SIGN;
              arg_negative_next = 1'b0;
            end else if (b == vcef_pkg::CH_MINUS) begin
              arg_status_next   = vcef_pkg::ARG_SIGN;
              arg_negative_next = 1'b1;
            end else if (is_digit) begin
              arg_status_next = vcef_pkg::ARG_DIGITS;
              arg_value_next  = {4'd0, digit_val};
            end else begin
              arg_status_next   = vcef_pkg::ARG_CLOSED;
              arg_value_next    = 8'd0;
              arg_negative_next = 1'b1;
            end
          end
          vcef_pkg::ARG_SIGN: begin
            if (is_digit) begin
              arg_status_next = vcef_pkg::ARG_DIGITS;
              arg_value_next  = {4'd0, digit_val};
            end else begin
              arg_status_next   = vcef_pkg::ARG_CLOSED;
              arg_value_next    = 8'd0;
              arg_negative_next = 1'b1;
            end
          end
          vcef_pkg::ARG_DIGITS: begin
            if (is_digit) begin
              arg_value_next = (arg_wide > 12'd255) ? vcef_pkg::ARG_SAT : arg_wide[7:0];
            end else begin
              arg_status_next = vcef_pkg::ARG_CLOSED;
              if (arg_value == 8'd0) arg_negative_next = 1'b0;
            end
          end
          vcef_pkg::ARG_CLOSED: ;
          default: ;
        endcase
      end
    end

    // column move: clamp, then spaces right or CR and spaces left
    if (move_en) begin
      if (tgt < 10'sd0) begin
        tc = '0;
      end else if (tgt > vcef_pkg::TGT_MAX) begin
        tc = vcef_pkg::LINE_END;
      end else begin
        tc = tgt[vcef_pkg::COL_W-1:0];
      end
      if (tc > print_column) begin
        cmd.runs[0] = {vcef_pkg::B_SP, tc - print_column, tc};
        k = 2'd1;
        print_column_next = tc;
      end else if (tc < print_column) begin
        cmd.runs[0] = {vcef_pkg::B_CR, 7'd1, 7'd0};
        k = 2'd1;
        print_column_next = '0;
        if (tc != '0) begin
          cmd.runs[1] = {vcef_pkg::B_SP, tc, tc};
          k = 2'd2;
          print_column_next = tc;
        end
      end
    end

    cmd.n_runs = k;
  end

  assign cmd_push = accept && (k != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_esc        <= 1'b0;
      seq_count     <= 2'd0;
      csi_flag      <= 1'b0;
      question_flag <= 1'b0;
      arg_value     <= 8'd0;
      arg_negative  <= 1'b0;
      arg_status    <= vcef_pkg::ARG_IDLE;
      print_column  <= '0;
      saved_column  <= '0;
      wrap_enable   <= 1'b0;
    end else if (accept) begin
      in_esc        <= in_esc_next;
      seq_count     <= seq_count_next;
      csi_flag      <= csi_flag_next;
      question_flag <= question_flag_next;
      arg_value     <= arg_value_next;
      arg_negative  <= arg_negative_next;
      arg_status    <= arg_status_next;
      print_column  <= print_column_next;
      saved_column  <= saved_column_next;
      wrap_enable   <= wrap_enable_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vcef_queue.sv =====
`default_nettype none

module vcef_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire vcef_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output vcef_pkg::cmd_t       head,
  output logic                 empty,
  output logic                 full
);

  vcef_pkg::cmd_t entries [vcef_pkg::QUEUE_DEPTH];
  logic [vcef_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [vcef_pkg::QUEUE_CW-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == vcef_pkg::QUEUE_CW'(vcef_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vcef_back.sv =====
`default_nettype none

module vcef_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire vcef_pkg::cmd_t  head,
  input  wire logic            empty,
  output logic                 pop,
  vcef_out_if.source           out_ch
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       is_last;
  vcef_pkg::run_t cur;

  logic [7:0] out_byte;
  logic [6:0] run_count;
  logic [6:0] column_after;
  logic       last_run;

  assign cur     = head.runs[idx];
  assign is_last = (idx == head.n_runs - 2'd1);
  assign load    = !empty && (!out_valid || out_ch.ready);
  assign pop     = load && is_last;

  assign out_ch.valid        = out_valid;
  assign out_ch.out_byte     = out_byte;
  assign out_ch.run_count    = run_count;
  assign out_ch.column_after = column_after;
  assign out_ch.last_run     = last_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= cur.ch;
      run_count    <= cur.count;
      column_after <= cur.col;
      last_run     <= is_last;
    end
  end

endmodule

`default_nettype wire
